### sv/bdq_pkg.sv
// Package for the bounded deque: operation and status codes, item types and the
// control bundle broadcast along the cell chain. No dependencies.

package bdq_pkg;

   localparam int DEFAULT_CAPACITY     = 256;
   localparam int DEFAULT_ELEMENT_BITS = 32;

   localparam logic [2:0] OP_INS_HEAD = 3'd0;
   localparam logic [2:0] OP_INS_TAIL = 3'd1;
   localparam logic [2:0] OP_REM_HEAD = 3'd2;
   localparam logic [2:0] OP_REM_TAIL = 3'd3;
   localparam logic [2:0] OP_RD_HEAD  = 3'd4;
   localparam logic [2:0] OP_RD_TAIL  = 3'd5;
   localparam logic [2:0] OP_RD_INDEX = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef logic [31:0] elem_type;
   typedef logic [8:0]  count_type;

   typedef struct packed {
      logic [2:0] operation;
      elem_type   element_in;
      logic [7:0] position;
   } req_type;

   typedef struct packed {
      elem_type   element_out;
      count_type  count;
      logic [1:0] status;
   } rsp_type;

   // Commands shared by every cell of the chain.
   typedef struct packed {
      logic push_front;   // every cell takes its lower neighbor, cell 0 the new item
      logic pop_front;    // every cell takes its upper neighbor
      logic write_at;     // the cell addressed by the target takes the new item
      logic lane_load;    // the addressed cell copies its entry onto the read lane
      logic lane_shift;   // the read lane moves one cell toward cell 0
   } cell_ctl_type;

endpackage

### sv/bdq_cell.sv
// One storage cell of the deque chain: an entry register and a read-lane register.
// Depends on bdq_pkg for the control bundle.

module bdq_cell #(
   parameter int ELEMENT_BITS = bdq_pkg::DEFAULT_ELEMENT_BITS,
   parameter int INDEX_BITS   = 8,
   parameter int INDEX        = 0
) (
   input  logic                     clock,
   input  bdq_pkg::cell_ctl_type    ctl,
   input  logic [INDEX_BITS-1:0]    target,
   input  logic [ELEMENT_BITS-1:0]  new_data,
   input  logic [ELEMENT_BITS-1:0]  lower_data,
   input  logic [ELEMENT_BITS-1:0]  upper_data,
   input  logic [ELEMENT_BITS-1:0]  upper_lane,
   output logic [ELEMENT_BITS-1:0]  data_out,
   output logic [ELEMENT_BITS-1:0]  lane_out
);

   logic [ELEMENT_BITS-1:0] data_ff;
   logic [ELEMENT_BITS-1:0] data_in;
   logic [ELEMENT_BITS-1:0] lane_ff;
   logic [ELEMENT_BITS-1:0] lane_in;
   logic                    hit;

   assign hit = (target == INDEX_BITS'(INDEX));

   always_comb begin
      data_in = data_ff;
      if (ctl.push_front) begin
         data_in = lower_data;
      end else if (ctl.pop_front) begin
         data_in = upper_data;
      end else if (ctl.write_at && hit) begin
         data_in = new_data;
      end
   end

   // The lane carries the selected entry down the chain, zeros elsewhere.
   always_comb begin
      lane_in = lane_ff;
      if (ctl.lane_load) begin
         lane_in = hit ? data_ff : '0;
      end else if (ctl.lane_shift) begin
         lane_in = upper_lane;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      lane_ff <= lane_in;
   end

   assign data_out = data_ff;
   assign lane_out = lane_ff;

endmodule

### sv/bdq_ctrl.sv
// Control for the deque: decodes each item, keeps the element count, drives the
// cell chain and holds the result register. Depends on bdq_pkg.

module bdq_ctrl #(
   parameter int CAPACITY   = bdq_pkg::DEFAULT_CAPACITY,
   parameter int INDEX_BITS = $clog2(CAPACITY),
   parameter int COUNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bdq_pkg::req_type       req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bdq_pkg::rsp_type       rsp_item,
   input  bdq_pkg::elem_type      lane_elem,
   output bdq_pkg::cell_ctl_type  ctl,
   output logic [INDEX_BITS-1:0]  target
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SEEK = 1'b1;
   localparam int   CMP_BITS = (COUNT_BITS > 8) ? COUNT_BITS : 8;

   logic                   state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [INDEX_BITS-1:0]  seek_ff, seek_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bdq_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   out_free;
   logic                   accept;
   logic                   full;
   logic                   empty;
   logic                   go_seek;
   logic [COUNT_BITS-1:0]  count_next;
   logic [1:0]             status;
   logic [INDEX_BITS-1:0]  dec_target;
   logic                   dec_push, dec_pop, dec_write;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == COUNT_BITS'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      go_seek    = 1'b0;
      count_next = count_ff;
      status     = bdq_pkg::ST_OK;
      dec_target = count_ff[INDEX_BITS-1:0];
      dec_push   = 1'b0;
      dec_pop    = 1'b0;
      dec_write  = 1'b0;
      unique case (req_item.operation) inside
         bdq_pkg::OP_INS_HEAD, bdq_pkg::OP_INS_TAIL: begin
            if (full) begin
               status = bdq_pkg::ST_FULL;
            end else begin
               count_next = count_ff + COUNT_BITS'(1);
               if (req_item.operation == bdq_pkg::OP_INS_HEAD) begin
                  dec_push = 1'b1;
               end else begin
                  dec_write = 1'b1;
               end
            end
         end
         bdq_pkg::OP_REM_HEAD, bdq_pkg::OP_REM_TAIL: begin
            if (empty) begin
               status = bdq_pkg::ST_EMPTY;
            end else begin
               count_next = count_ff - COUNT_BITS'(1);
               dec_pop    = (req_item.operation == bdq_pkg::OP_REM_HEAD);
            end
         end
         bdq_pkg::OP_RD_HEAD, bdq_pkg::OP_RD_TAIL, bdq_pkg::OP_RD_INDEX: begin
            if (empty) begin
               status = bdq_pkg::ST_EMPTY;
            end else if (req_item.operation == bdq_pkg::OP_RD_HEAD) begin
               go_seek    = 1'b1;
               dec_target = '0;
            end else if (req_item.operation == bdq_pkg::OP_RD_TAIL) begin
               go_seek    = 1'b1;
               dec_target = INDEX_BITS'(count_ff - COUNT_BITS'(1));
            end else if (CMP_BITS'(req_item.position) >= CMP_BITS'(count_ff)) begin
               status = bdq_pkg::ST_RANGE;
            end else begin
               go_seek    = 1'b1;
               dec_target = INDEX_BITS'(req_item.position);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      seek_in           = seek_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_in            = rsp_ff;
      ctl               = '0;
      target            = dec_target;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               count_in       = count_next;
               ctl.push_front = dec_push;
               ctl.pop_front  = dec_pop;
               ctl.write_at   = dec_write;
               if (go_seek) begin
                  ctl.lane_load = 1'b1;
                  seek_in       = dec_target;
                  state_in      = S_SEEK;
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.element_out = '0;
                  rsp_in.count       = bdq_pkg::count_type'(count_next);
                  rsp_in.status      = status;
               end
            end
         end
         S_SEEK: begin
            if (seek_ff != '0) begin
               ctl.lane_shift = 1'b1;
               seek_in        = seek_ff - INDEX_BITS'(1);
            end else if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.element_out = lane_elem;
               rsp_in.count       = bdq_pkg::count_type'(count_ff);
               rsp_in.status      = bdq_pkg::ST_OK;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seek_ff <= seek_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### sv/bounded_deque.sv
// Bounded double-ended queue built as a chain of storage cells, where cell i holds
// the element at position i from the head. Insert head shifts the whole chain up
// by one cell, remove head shifts it down, insert tail writes the cell at the
// current count and remove tail only lowers the count, so each of these items,
// and any item that fails with a full, empty or range status, is done without a seek.
// A read copies the chosen entry onto a read lane that runs alongside the chain
// and moves one cell toward cell 0 per cycle, so a read of position p (head is
// 0, tail is count-1) moves p cells down before its result is registered; that
// lane is what sets the read time. The result register holds a single result, so
// the next item is accepted only once the previous result is taken, at the earliest
// in the same cycle. There is no clearing pass after reset: the count starts at
// zero and only written entries are ever read.
// Depends on bdq_pkg, bdq_ctrl and bdq_cell.

module bounded_deque #(
   parameter int CAPACITY     = bdq_pkg::DEFAULT_CAPACITY,
   parameter int ELEMENT_BITS = bdq_pkg::DEFAULT_ELEMENT_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdq_pkg::req_type  req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bdq_pkg::rsp_type  rsp_item
);

   localparam int INDEX_BITS = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   bdq_pkg::cell_ctl_type    ctl;
   logic [INDEX_BITS-1:0]    target;
   logic [ELEMENT_BITS-1:0]  new_elem;
   bdq_pkg::elem_type        lane_elem;
   logic [ELEMENT_BITS-1:0]  data_w [CAPACITY];
   logic [ELEMENT_BITS-1:0]  lane_w [CAPACITY];

   // Stored elements keep ELEMENT_BITS bits; results are 32 bits wide.
   generate
      if (ELEMENT_BITS <= 32) begin : g_narrow
         assign new_elem  = req_item.element_in[ELEMENT_BITS-1:0];
         assign lane_elem = 32'(lane_w[0]);
      end else begin : g_wide
         assign new_elem  = {{(ELEMENT_BITS - 32){1'b0}}, req_item.element_in};
         assign lane_elem = lane_w[0][31:0];
      end
   endgenerate

   bdq_ctrl #(
      .CAPACITY   (CAPACITY),
      .INDEX_BITS (INDEX_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .lane_elem (lane_elem),
      .ctl       (ctl),
      .target    (target)
   );

   // The chain: each cell sees its two neighbors' entries and the lane above it.
   // Cell 0 takes the new item on a head insert; the top cell sees zeros above.
   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic [ELEMENT_BITS-1:0] lower;
         logic [ELEMENT_BITS-1:0] upper;
         logic [ELEMENT_BITS-1:0] upper_lane;

         if (i == 0) begin : g_first
            assign lower = new_elem;
         end else begin : g_inner_lo
            assign lower = data_w[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign upper      = '0;
            assign upper_lane = '0;
         end else begin : g_inner_hi
            assign upper      = data_w[i+1];
            assign upper_lane = lane_w[i+1];
         end

         bdq_cell #(
            .ELEMENT_BITS (ELEMENT_BITS),
            .INDEX_BITS   (INDEX_BITS),
            .INDEX        (i)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .target     (target),
            .new_data   (new_elem),
            .lower_data (lower),
            .upper_data (upper),
            .upper_lane (upper_lane),
            .data_out   (data_w[i]),
            .lane_out   (lane_w[i])
         );
      end
   endgenerate

endmodule
